### design/lzsf_pkg.sv
// Package with the shared constants, types and helper functions of the LZ4 sequence formatter.
package lzsf_pkg;

    localparam int unsigned MIN_MATCH  = 4;
    localparam int unsigned LEN_BOUND  = 4095;
    localparam int unsigned LEN_W      = 12;
    localparam int unsigned OFF_W      = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned NIB_W      = 4;
    localparam int unsigned NIB_MAX    = 15;
    localparam int unsigned EXT_RUN    = 255;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    // Item opcodes.
    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_LITERAL = 1'b1;

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [OFF_W-1:0]  off_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [NIB_W-1:0]  nib_t;

    // One unit of output work, produced by the front end for one accepted item.
    typedef struct packed {
        logic  is_hdr;    // job starts with a token byte
        byte_t token;
        logic  lit_ext;   // literal-length extension bytes follow the token
        len_t  lit_rest;  // literal count minus 15
        byte_t lit;       // literal byte for a literal job
        logic  tail;      // offset and match extension bytes close the job
        off_t  off;
        logic  ml_ext;    // match-length extension bytes follow the offset
        len_t  ml_rest;   // match code minus 15
    } job_t;

    function automatic len_t clamp_len(len_t v);
        len_t r;
        r = (32'(v) > LEN_BOUND) ? len_t'(LEN_BOUND) : v;
        return r;
    endfunction

    function automatic len_t match_code(len_t ml);
        len_t r;
        r = (32'(ml) > MIN_MATCH) ? ml - len_t'(MIN_MATCH) : '0;
        return r;
    endfunction

endpackage

### design/lzsf_if.sv
// Handshake interfaces for the sequence input channel and the byte output channel.
interface lzsf_in_if;
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    lzsf_pkg::len_t       literal_count;
    logic                 has_match;
    lzsf_pkg::len_t       match_length;
    lzsf_pkg::off_t       match_offset;
    lzsf_pkg::byte_t      literal_byte;

    modport source (output valid, opcode, literal_count, has_match, match_length,
                    match_offset, literal_byte, input ready);
    modport sink   (input valid, opcode, literal_count, has_match, match_length,
                    match_offset, literal_byte, output ready);
    modport monitor (input valid, ready, opcode, literal_count, has_match, match_length,
                     match_offset, literal_byte);
endinterface

interface lzsf_out_if;
    logic            valid;
    logic            ready;
    lzsf_pkg::byte_t out_byte;
    logic            last_of_item;

    modport source  (output valid, out_byte, last_of_item, input ready);
    modport sink    (input valid, out_byte, last_of_item, output ready);
    modport monitor (input valid, ready, out_byte, last_of_item);
endinterface

### design/lzsf_front.sv
// Front end: accepts items, tracks the open sequence and turns items into output jobs.
module lzsf_front (
    input  logic           clk,
    input  logic           rst_n,
    lzsf_in_if.sink        seq,
    output lzsf_pkg::job_t job,
    output logic           job_push,
    input  logic           job_full
);
    import lzsf_pkg::*;

    len_t left_reg,      left_next;
    logic pend_reg,      pend_next;
    logic pend_ext_reg,  pend_ext_next;
    len_t pend_rest_reg, pend_rest_next;
    off_t pend_off_reg,  pend_off_next;

    logic accept;
    len_t lc;
    len_t ml;
    len_t code;
    logic ml_ext;
    nib_t hi;
    nib_t lo;

    assign seq.ready = !job_full;
    assign accept    = seq.valid && seq.ready;

    always_comb
    begin
        lc     = clamp_len(seq.literal_count);
        ml     = clamp_len(seq.match_length);
        code   = match_code(ml);
        ml_ext = (code >= len_t'(NIB_MAX));
        hi     = (lc >= len_t'(NIB_MAX)) ? nib_t'(NIB_MAX) : lc[NIB_W-1:0];
        lo     = '0;
        if (seq.has_match)
        begin
            lo = ml_ext ? nib_t'(NIB_MAX) : code[NIB_W-1:0];
        end

        job            = '0;
        job_push       = 1'b0;
        left_next      = left_reg;
        pend_next      = pend_reg;
        pend_ext_next  = pend_ext_reg;
        pend_rest_next = pend_rest_reg;
        pend_off_next  = pend_off_reg;

        if (accept)
        begin
            if (seq.opcode == OP_HEADER)
            begin
                // A new header always drops whatever sequence was still open.
                left_next = '0;
                pend_next = 1'b0;
                if (lc != '0 || seq.has_match)
                begin
                    job_push     = 1'b1;
                    job.is_hdr   = 1'b1;
                    job.token    = {hi, lo};
                    job.lit_ext  = (lc >= len_t'(NIB_MAX));
                    job.lit_rest = lc - len_t'(NIB_MAX);
                    job.off      = seq.match_offset;
                    job.ml_ext   = ml_ext;
                    job.ml_rest  = code - len_t'(NIB_MAX);
                    if (lc == '0)
                    begin
                        job.tail = 1'b1;
                    end
                    else
                    begin
                        left_next      = lc;
                        pend_next      = seq.has_match;
                        pend_ext_next  = ml_ext;
                        pend_rest_next = code - len_t'(NIB_MAX);
                        pend_off_next  = seq.match_offset;
                    end
                end
            end
            else if (left_reg != '0)
            begin
                job_push  = 1'b1;
                job.lit   = seq.literal_byte;
                left_next = left_reg - len_t'(1);
                if (left_reg == len_t'(1))
                begin
                    job.tail    = pend_reg;
                    job.off     = pend_off_reg;
                    job.ml_ext  = pend_ext_reg;
                    job.ml_rest = pend_rest_reg;
                    pend_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            left_reg <= left_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_ext_reg  <= pend_ext_next;
        pend_rest_reg <= pend_rest_next;
        pend_off_reg  <= pend_off_next;
    end

endmodule

### design/lzsf_fifo.sv
// Short job queue between the front end and the byte sequencer.
module lzsf_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lzsf_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output lzsf_pkg::job_t head,
    output logic           empty
);
    import lzsf_pkg::*;

    job_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg,  count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### design/lzsf_back.sv
// Byte sequencer: expands each job into output bytes, one byte per cycle while the sink is ready.
module lzsf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  lzsf_pkg::job_t job_head,
    input  logic           job_valid,
    output logic           job_pop,
    lzsf_out_if.source     blk
);
    import lzsf_pkg::*;

    localparam logic [2:0] PH_TOKEN = 3'd0;
    localparam logic [2:0] PH_LEXT  = 3'd1;
    localparam logic [2:0] PH_LIT   = 3'd2;
    localparam logic [2:0] PH_OFF0  = 3'd3;
    localparam logic [2:0] PH_OFF1  = 3'd4;
    localparam logic [2:0] PH_MEXT  = 3'd5;

    logic       busy_reg,      busy_next;
    logic [2:0] phase_reg,     phase_next;
    len_t       rest_reg,      rest_next;
    job_t       cur_reg,       cur_next;
    logic       out_valid_reg, out_valid_next;
    byte_t      out_byte_reg,  out_byte_next;
    logic       out_last_reg,  out_last_next;

    job_t       src;
    logic [2:0] ph;
    logic [2:0] ph_n;
    len_t       rest_n;
    byte_t      byte_n;
    logic       done;
    logic       advance;
    logic       step;

    assign blk.valid        = out_valid_reg;
    assign blk.out_byte     = out_byte_reg;
    assign blk.last_of_item = out_last_reg;

    assign advance = !out_valid_reg || blk.ready;
    assign step    = advance && (busy_reg || job_valid);
    assign job_pop = step && !busy_reg;

    always_comb
    begin
        src = busy_reg ? cur_reg : job_head;
        if (busy_reg)
        begin
            ph = phase_reg;
        end
        else
        begin
            ph = job_head.is_hdr ? PH_TOKEN : PH_LIT;
        end

        byte_n = '0;
        done   = 1'b1;
        ph_n   = ph;
        rest_n = rest_reg;

        case (ph)
            PH_TOKEN:
            begin
                byte_n = src.token;
                if (src.lit_ext)
                begin
                    done   = 1'b0;
                    ph_n   = PH_LEXT;
                    rest_n = src.lit_rest;
                end
                else if (src.tail)
                begin
                    done = 1'b0;
                    ph_n = PH_OFF0;
                end
            end
            PH_LEXT:
            begin
                if (rest_reg >= len_t'(EXT_RUN))
                begin
                    byte_n = byte_t'(EXT_RUN);
                    rest_n = rest_reg - len_t'(EXT_RUN);
                    done   = 1'b0;
                end
                else
                begin
                    byte_n = rest_reg[BYTE_W-1:0];
                    if (src.tail)
                    begin
                        done = 1'b0;
                        ph_n = PH_OFF0;
                    end
                end
            end
            PH_LIT:
            begin
                byte_n = src.lit;
                if (src.tail)
                begin
                    done = 1'b0;
                    ph_n = PH_OFF0;
                end
            end
            PH_OFF0:
            begin
                byte_n = src.off[BYTE_W-1:0];
                done   = 1'b0;
                ph_n   = PH_OFF1;
            end
            PH_OFF1:
            begin
                byte_n = src.off[OFF_W-1:BYTE_W];
                if (src.ml_ext)
                begin
                    done   = 1'b0;
                    ph_n   = PH_MEXT;
                    rest_n = src.ml_rest;
                end
            end
            PH_MEXT:
            begin
                if (rest_reg >= len_t'(EXT_RUN))
                begin
                    byte_n = byte_t'(EXT_RUN);
                    rest_n = rest_reg - len_t'(EXT_RUN);
                    done   = 1'b0;
                end
                else
                begin
                    byte_n = rest_reg[BYTE_W-1:0];
                end
            end
            default:
            begin
                byte_n = '0;
                done   = 1'b1;
            end
        endcase

        busy_next      = busy_reg;
        phase_next     = phase_reg;
        rest_next      = rest_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (step)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = byte_n;
            out_last_next  = done;
            busy_next      = !done;
            cur_next       = src;
            phase_next     = ph_n;
            rest_next      = rest_n;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_TOKEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg     <= rest_next;
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

### design/lz4_sequence_formatter.sv
// Top level of the LZ4 sequence formatter: front end, job queue and byte sequencer.
// With the queue and the sequencer idle, an accepted item is written into the job queue
// and its first byte then into the sequencer's output register.
// The sequencer emits one output byte per cycle while the sink is ready; a plain literal
// emits one byte, and a header or a literal that closes a match adds one more byte
// for each token, extension and offset byte it carries.
// The four-entry job queue lets input items keep arriving while a header's bytes drain.
// Reset (rst_n low, asynchronous) empties the queue, drops any open sequence and
// clears the output valid; input ready is high as soon as reset is released.
module lz4_sequence_formatter (
    input  logic       clk,
    input  logic       rst_n,
    lzsf_in_if.sink    seq,
    lzsf_out_if.source blk
);
    import lzsf_pkg::*;

    // The front end classifies each accepted item. A header's job carries the
    // token, the literal extension length and, with no literals, the match
    // tail; else the tail is parked in the front end until the sequence's
    // last literal comes, then rides with that literal's job. Headers with no
    // literals and no match, and literals outside a sequence, produce no job.
    job_t front_job;
    logic front_push;
    logic queue_full;

    // The queue head feeds the sequencer, which walks one job at a time through
    // its byte phases. It pops a job in the same cycle it emits that job's first
    // byte, so there is no bubble between jobs and literal jobs flow at one per
    // cycle while the sink is ready.
    job_t queue_head;
    logic queue_empty;
    logic queue_pop;

    lzsf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .seq      (seq),
        .job      (front_job),
        .job_push (front_push),
        .job_full (queue_full)
    );

    lzsf_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_job (front_job),
        .full     (queue_full),
        .pop      (queue_pop),
        .head     (queue_head),
        .empty    (queue_empty)
    );

    // The sequencer's output register holds each byte until the sink takes it;
    // the job queue keeps a stalled sink from holding up the front end until
    // the queue fills.
    lzsf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_head  (queue_head),
        .job_valid (!queue_empty),
        .job_pop   (queue_pop),
        .blk       (blk)
    );

endmodule

### design/lzsf_checker.sv
// Port-level assertions for the LZ4 sequence formatter and the bind that attaches them.
module lzsf_checker (
    input logic        clk,
    input logic        rst_n,
    lzsf_in_if.sink    seq,
    lzsf_out_if.source blk
);

    // A stalled output byte stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        blk.valid && !blk.ready |=> blk.valid)
        else $error("output valid dropped while stalled");

    // A stalled output byte keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        blk.valid && !blk.ready |=> $stable(blk.out_byte) && $stable(blk.last_of_item))
        else $error("output payload changed while stalled");

    // Nothing is offered downstream while reset is held.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !blk.valid)
        else $error("output valid during reset");

    // Right after reset the queue is empty: input ready, no byte pending.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> seq.ready && !blk.valid)
        else $error("block not empty after reset release");

endmodule

bind lz4_sequence_formatter lzsf_checker u_lzsf_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .seq   (seq),
    .blk   (blk)
);
